>>> sv/stds_pkg.sv
// ----------------------------------------------------------------------------
// stds_pkg
// Types, codes and constants shared by the screen table download sequencer.
// ----------------------------------------------------------------------------
package stds_pkg;

    localparam int MAX_TABLES = 16;

    typedef enum logic [3:0] {
        ACT_START     = 4'd0,
        ACT_CANCEL    = 4'd1,
        ACT_INIT_OK   = 4'd2,
        ACT_INIT_ERR  = 4'd3,
        ACT_ENTRY_OK  = 4'd4,
        ACT_ENTRY_ERR = 4'd5,
        ACT_UNIT_MISS = 4'd6,
        ACT_NODE_MISS = 4'd7,
        ACT_TIMEOUT   = 4'd8,
        ACT_DONE_OK   = 4'd9,
        ACT_DONE_ERR  = 4'd10,
        ACT_LOAD      = 4'd11
    } act_t;

    typedef enum logic [3:0] {
        K_STOP     = 4'd0,
        K_START    = 4'd1,
        K_INIT     = 4'd2,
        K_ENTRY    = 4'd3,
        K_DONE     = 4'd4,
        K_NSTART   = 4'd5,
        K_NINITOK  = 4'd6,
        K_NINITERR = 4'd7,
        K_NWRITE   = 4'd8,
        K_NENTOK   = 4'd9,
        K_NENTERR  = 4'd10,
        K_ERRNODE  = 4'd11,
        K_ERRUNIT  = 4'd12,
        K_FINOK    = 4'd13,
        K_FINERR   = 4'd14,
        K_FINCAN   = 4'd15
    } kind_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WINIT,
        ST_WENTRY,
        ST_WDONE,
        ST_STOPC,
        ST_FINCAN,
        ST_STOPF,
        ST_FINERR,
        ST_STOPI,
        ST_NOTE,
        ST_NINITOK,
        ST_NWRITE,
        ST_ENTRY,
        ST_STARTE,
        ST_TEND,
        ST_DONE,
        ST_STARTD,
        ST_TNEXT,
        ST_TCHK,
        ST_STOPE,
        ST_NENTOK,
        ST_STOPD,
        ST_SCAN,
        ST_NSTART,
        ST_INIT,
        ST_STARTI
    } state_t;

    localparam logic [3:0] ADDR_TABLE_COUNT = 4'd0;
    localparam logic [3:0] ADDR_NEW_NODE    = 4'd4;
    localparam logic [3:0] ADDR_RETRY       = 4'd8;

    typedef struct packed {
        logic  emit;
        kind_t kind;
        logic  flush;
        logic  clr_pos;
        logic  inc_pos;
        logic  clr_ent;
        logic  inc_ent;
        logic  ld_ret;
        logic  dec_ret;
        logic  clr_ret;
        logic  load_wr;
    } dp_cmd_t;

    typedef struct packed {
        logic emit_ok;
        logic pend_valid;
        logic pos_lt_len;
        logic present;
        logic ent_lt_tot;
        logic ent_nx_lt_tot;
        logic ret_gt1;
        logic new_node;
    } dp_sts_t;

endpackage

>>> sv/stds_ctrl.sv
// ----------------------------------------------------------------------------
// stds_ctrl
// Sequencer state machine: decodes events and steps through the command words.
// ----------------------------------------------------------------------------
module stds_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [3:0]         in_action,
    output logic               in_ready,
    input  stds_pkg::dp_sts_t  sts,
    output stds_pkg::dp_cmd_t  cmd
);

    stds_pkg::state_t state_reg, state_next;
    logic [3:0]       act_reg;
    logic             acc;
    logic             waiting;

    assign waiting  = (state_reg == stds_pkg::ST_IDLE) || (state_reg == stds_pkg::ST_WINIT) ||
                      (state_reg == stds_pkg::ST_WENTRY) || (state_reg == stds_pkg::ST_WDONE);
    assign in_ready = waiting && !sts.pend_valid;
    assign acc      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stds_pkg::ST_IDLE;
            act_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (acc)
            begin
                act_reg <= in_action;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (waiting)
        begin
            if (acc && in_action < stds_pkg::ACT_LOAD)
            begin
                if (in_action == stds_pkg::ACT_CANCEL)
                begin
                    state_next = stds_pkg::ST_STOPC;
                end
                else
                begin
                    case (state_reg)
                        stds_pkg::ST_IDLE:
                        begin
                            state_next = (in_action == stds_pkg::ACT_START) ?
                                         stds_pkg::ST_SCAN : stds_pkg::ST_STOPF;
                        end
                        stds_pkg::ST_WINIT:  state_next = stds_pkg::ST_STOPI;
                        stds_pkg::ST_WENTRY: state_next = stds_pkg::ST_STOPE;
                        default:
                        begin
                            if (in_action != stds_pkg::ACT_START)
                            begin
                                state_next = stds_pkg::ST_STOPD;
                            end
                        end
                    endcase
                end
            end
        end
        else if (sts.emit_ok)
        begin
            case (state_reg)
                stds_pkg::ST_STOPC:  state_next = stds_pkg::ST_FINCAN;
                stds_pkg::ST_FINCAN: state_next = stds_pkg::ST_IDLE;
                stds_pkg::ST_STOPF:  state_next = stds_pkg::ST_FINERR;
                stds_pkg::ST_FINERR: state_next = stds_pkg::ST_IDLE;
                stds_pkg::ST_STOPI:
                begin
                    if (act_reg == stds_pkg::ACT_INIT_OK)
                        state_next = stds_pkg::ST_NINITOK;
                    else if (act_reg == stds_pkg::ACT_INIT_ERR)
                        state_next = stds_pkg::ST_NOTE;
                    else
                        state_next = stds_pkg::ST_FINERR;
                end
                stds_pkg::ST_NOTE:   state_next = stds_pkg::ST_FINERR;
                stds_pkg::ST_NINITOK:
                    state_next = sts.ent_lt_tot ? stds_pkg::ST_NWRITE : stds_pkg::ST_TEND;
                stds_pkg::ST_NWRITE: state_next = stds_pkg::ST_ENTRY;
                stds_pkg::ST_ENTRY:  state_next = stds_pkg::ST_STARTE;
                stds_pkg::ST_STARTE: state_next = stds_pkg::ST_WENTRY;
                stds_pkg::ST_TEND:
                    state_next = sts.new_node ? stds_pkg::ST_DONE : stds_pkg::ST_TNEXT;
                stds_pkg::ST_DONE:   state_next = stds_pkg::ST_STARTD;
                stds_pkg::ST_STARTD: state_next = stds_pkg::ST_WDONE;
                stds_pkg::ST_TNEXT:  state_next = stds_pkg::ST_TCHK;
                stds_pkg::ST_TCHK:
                begin
                    if (sts.pos_lt_len && sts.present)
                        state_next = stds_pkg::ST_NSTART;
                    else
                        state_next = stds_pkg::ST_IDLE;
                end
                stds_pkg::ST_STOPE:
                begin
                    case (act_reg)
                        stds_pkg::ACT_ENTRY_OK:  state_next = stds_pkg::ST_NENTOK;
                        stds_pkg::ACT_TIMEOUT:
                            state_next = sts.ret_gt1 ? stds_pkg::ST_STARTE : stds_pkg::ST_FINERR;
                        stds_pkg::ACT_ENTRY_ERR,
                        stds_pkg::ACT_UNIT_MISS,
                        stds_pkg::ACT_NODE_MISS: state_next = stds_pkg::ST_NOTE;
                        default:                 state_next = stds_pkg::ST_FINERR;
                    endcase
                end
                stds_pkg::ST_NENTOK:
                    state_next = sts.ent_nx_lt_tot ? stds_pkg::ST_NWRITE : stds_pkg::ST_TEND;
                stds_pkg::ST_STOPD:
                begin
                    if (act_reg == stds_pkg::ACT_DONE_OK || act_reg == stds_pkg::ACT_TIMEOUT)
                        state_next = stds_pkg::ST_TNEXT;
                    else
                        state_next = stds_pkg::ST_FINERR;
                end
                stds_pkg::ST_SCAN:
                begin
                    if (!sts.pos_lt_len)
                        state_next = stds_pkg::ST_IDLE;
                    else if (sts.present)
                        state_next = stds_pkg::ST_NSTART;
                end
                stds_pkg::ST_NSTART: state_next = stds_pkg::ST_INIT;
                stds_pkg::ST_INIT:   state_next = stds_pkg::ST_STARTI;
                stds_pkg::ST_STARTI: state_next = stds_pkg::ST_WINIT;
                default:             state_next = stds_pkg::ST_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.kind    = stds_pkg::K_STOP;
        cmd.flush   = waiting && sts.pend_valid;
        cmd.load_wr = acc && (in_action == stds_pkg::ACT_LOAD);
        cmd.clr_pos = acc && (state_reg == stds_pkg::ST_IDLE) &&
                      (in_action == stds_pkg::ACT_START);
        if (!waiting && sts.emit_ok)
        begin
            case (state_reg)
                stds_pkg::ST_STOPC, stds_pkg::ST_STOPF, stds_pkg::ST_STOPI,
                stds_pkg::ST_STOPE, stds_pkg::ST_STOPD:
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = stds_pkg::K_STOP;
                    if (state_reg == stds_pkg::ST_STOPE && act_reg == stds_pkg::ACT_TIMEOUT)
                    begin
                        cmd.dec_ret = sts.ret_gt1;
                        cmd.clr_ret = !sts.ret_gt1;
                    end
                end
                stds_pkg::ST_FINCAN:
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = stds_pkg::K_FINCAN;
                end
                stds_pkg::ST_FINERR:
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = stds_pkg::K_FINERR;
                end
                stds_pkg::ST_NOTE:
                begin
                    cmd.emit = 1'b1;
                    case (act_reg)
                        stds_pkg::ACT_INIT_ERR:  cmd.kind = stds_pkg::K_NINITERR;
                        stds_pkg::ACT_ENTRY_ERR: cmd.kind = stds_pkg::K_NENTERR;
                        stds_pkg::ACT_UNIT_MISS: cmd.kind = stds_pkg::K_ERRNODE;
                        default:                 cmd.kind = stds_pkg::K_ERRUNIT;
                    endcase
                end
                stds_pkg::ST_NINITOK:
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = stds_pkg::K_NINITOK;
                end
                stds_pkg::ST_NWRITE:
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = stds_pkg::K_NWRITE;
                end
                stds_pkg::ST_ENTRY:
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = stds_pkg::K_ENTRY;
                    cmd.ld_ret = 1'b1;
                end
                stds_pkg::ST_STARTE, stds_pkg::ST_STARTD, stds_pkg::ST_STARTI:
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = stds_pkg::K_START;
                end
                stds_pkg::ST_DONE:
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = stds_pkg::K_DONE;
                end
                stds_pkg::ST_TNEXT:
                begin
                    cmd.inc_pos = 1'b1;
                end
                stds_pkg::ST_TCHK:
                begin
                    if (sts.pos_lt_len && sts.present)
                    begin
                        cmd.clr_ent = 1'b1;
                        cmd.clr_ret = 1'b1;
                    end
                    else
                    begin
                        cmd.emit = 1'b1;
                        cmd.kind = sts.pos_lt_len ? stds_pkg::K_FINERR : stds_pkg::K_FINOK;
                    end
                end
                stds_pkg::ST_NENTOK:
                begin
                    cmd.emit    = 1'b1;
                    cmd.kind    = stds_pkg::K_NENTOK;
                    cmd.inc_ent = 1'b1;
                end
                stds_pkg::ST_SCAN:
                begin
                    if (sts.pos_lt_len)
                    begin
                        if (sts.present)
                        begin
                            cmd.clr_ent = 1'b1;
                            cmd.clr_ret = 1'b1;
                        end
                        else
                        begin
                            cmd.emit    = 1'b1;
                            cmd.kind    = stds_pkg::K_FINERR;
                            cmd.inc_pos = 1'b1;
                        end
                    end
                end
                stds_pkg::ST_NSTART:
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = stds_pkg::K_NSTART;
                end
                stds_pkg::ST_INIT:
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = stds_pkg::K_INIT;
                end
                default:
                begin
                    cmd.emit = 1'b0;
                end
            endcase
        end
    end

endmodule

>>> sv/stds_dp.sv
// ----------------------------------------------------------------------------
// stds_dp
// Datapath: positions, retry count, table store, configuration and output words.
// ----------------------------------------------------------------------------
module stds_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  stds_pkg::dp_cmd_t  cmd,
    output stds_pkg::dp_sts_t  sts,
    input  logic [3:0]         load_index,
    input  logic               load_present,
    input  logic [7:0]         load_entries,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,
    output logic [3:0]         m_tuser,
    output logic               m_tlast
);

    logic [4:0]  table_count_reg;
    logic        new_node_reg;
    logic [7:0]  retry_reload_reg;
    logic [4:0]  pos_reg;
    logic [7:0]  ent_reg;
    logic [7:0]  ret_reg;
    logic [8:0]  info_mem [stds_pkg::MAX_TABLES];
    logic        pend_valid_reg;
    logic [23:0] pend_reg;
    logic        out_valid_reg;
    logic [23:0] out_reg;
    logic        out_last_reg;
    logic [4:0]  list_len;
    logic [8:0]  cur_info;
    logic [7:0]  cur_total;
    logic        out_free;
    logic        do_emit;
    logic        do_flush;
    logic [8:0]  ent_plus;

    assign list_len  = (table_count_reg > 5'(stds_pkg::MAX_TABLES)) ?
                       5'(stds_pkg::MAX_TABLES) : table_count_reg;
    assign cur_info  = pos_reg[4] ? 9'd0 : info_mem[pos_reg[3:0]];
    assign cur_total = cur_info[7:0];
    assign ent_plus  = {1'b0, ent_reg} + 9'd1;
    assign out_free  = !out_valid_reg || m_tready;
    assign do_emit   = cmd.emit;
    assign do_flush  = cmd.flush && out_free;

    always_comb
    begin
        sts.emit_ok       = !pend_valid_reg || out_free;
        sts.pend_valid    = pend_valid_reg;
        sts.pos_lt_len    = pos_reg < list_len;
        sts.present       = cur_info[8];
        sts.ent_lt_tot    = ent_reg < cur_total;
        sts.ent_nx_lt_tot = ent_plus < {1'b0, cur_total};
        sts.ret_gt1       = ret_reg > 8'd1;
        sts.new_node      = new_node_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            info_mem[load_index] <= {load_present, load_entries};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_count_reg  <= 5'd0;
            new_node_reg     <= 1'b0;
            retry_reload_reg <= 8'd3;
            pos_reg          <= 5'd0;
            ent_reg          <= 8'd0;
            ret_reg          <= 8'd0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                case (paddr)
                    stds_pkg::ADDR_TABLE_COUNT: table_count_reg  <= pwdata[4:0];
                    stds_pkg::ADDR_NEW_NODE:    new_node_reg     <= pwdata[0];
                    stds_pkg::ADDR_RETRY:       retry_reload_reg <= pwdata[7:0];
                    default:                    table_count_reg  <= table_count_reg;
                endcase
            end
            if (cmd.clr_pos)
                pos_reg <= 5'd0;
            else if (cmd.inc_pos)
                pos_reg <= pos_reg + 5'd1;
            if (cmd.clr_ent)
                ent_reg <= 8'd0;
            else if (cmd.inc_ent)
                ent_reg <= ent_plus[7:0];
            if (cmd.clr_ret)
                ret_reg <= 8'd0;
            else if (cmd.ld_ret)
                ret_reg <= retry_reload_reg;
            else if (cmd.dec_ret)
                ret_reg <= ret_reg - 8'd1;

            if (do_emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (do_flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if ((do_emit && pend_valid_reg) || do_flush)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= do_flush;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            pend_reg <= {cur_total, ent_reg, pos_reg[3:0], cmd.kind};
        end
        if ((do_emit && pend_valid_reg) || do_flush)
        begin
            out_reg <= pend_reg;
        end
    end

    always_comb
    begin
        case (paddr)
            stds_pkg::ADDR_TABLE_COUNT: prdata = {27'd0, table_count_reg};
            stds_pkg::ADDR_NEW_NODE:    prdata = {31'd0, new_node_reg};
            stds_pkg::ADDR_RETRY:       prdata = {24'd0, retry_reload_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg[23:4]};
    assign m_tuser  = out_reg[3:0];
    assign m_tlast  = out_last_reg;

endmodule

>>> sv/screen_table_download_sequencer_core.sv
// ----------------------------------------------------------------------------
// screen_table_download_sequencer_core
// Sequences screen table downloads to a display node as a command word stream.
// ----------------------------------------------------------------------------
// Output: each command word passes a pending register and then the output
// register; a stall on m_tready holds the sequence until the output is free.
// Input: an event holds s_tready low until all of its result words are issued
// and the last word is flushed from the pending stage; no new event is taken sooner.
// Reset: rst_n clears control, position and configuration registers at once;
// the table store holds no reset value and must be loaded before use.
module screen_table_download_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // load_index[3:0], load_present[4],
                                   // load_entries[12:5], zero[15:13]
    input  logic [3:0]  s_tuser,   // action[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // table_index[3:0], entry_index[11:4],
                                   // entry_total[19:12], zero[23:20]
    output logic [3:0]  m_tuser,   // kind[3:0]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    stds_pkg::dp_cmd_t cmd;
    stds_pkg::dp_sts_t sts;

    assign pready = 1'b1;

    stds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .in_ready  (s_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    stds_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .load_index   (s_tdata[3:0]),
        .load_present (s_tdata[4]),
        .load_entries (s_tdata[12:5]),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule
